/* hw/rtl/hash_table_builder_linear_probe_core_assert.svh */
// assertion macros for the hash table builder
`ifndef HASH_TABLE_BUILDER_LINEAR_PROBE_CORE_ASSERT_SVH
`define HASH_TABLE_BUILDER_LINEAR_PROBE_CORE_ASSERT_SVH

// antecedent holds, consequent holds in the same cycle
`define HTB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent holds, consequent holds in the next cycle
`define HTB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hw/rtl/htb_pkg.sv */
// shared constants and types for the hash table builder
package htb_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int NUM_BUCKETS = 256;
	localparam int ENTRY_BYTES = 16;

	localparam int ENT_AW  = $clog2(MAX_ENTRIES);
	localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
	localparam int SLOT_AW = $clog2(2 * MAX_ENTRIES);
	localparam int LEN_W   = CNT_W + 1;
	localparam int BKT_W   = $clog2(NUM_BUCKETS);
	localparam int DVD_W   = 64 - BKT_W;
	localparam int DIV_CW  = $clog2(DVD_W);

	localparam logic [63:0] WP_RESET = 64'(NUM_BUCKETS * ENTRY_BYTES);

	localparam logic FUNC_ADD  = 1'b0;
	localparam logic FUNC_NEXT = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OVF   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_PHASE = 2'd3;

	localparam logic [1:0] KIND_ACK  = 2'd0;
	localparam logic [1:0] KIND_SLOT = 2'd1;
	localparam logic [1:0] KIND_HDR  = 2'd2;

	typedef enum logic [1:0] {
		PH_ADD,
		PH_SLOT,
		PH_HDR,
		PH_DONE
	} phase_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ADD1,
		S_ADD2,
		S_ADD3,
		S_CLR,
		S_CNT_RD,
		S_CNT_W1,
		S_CNT_INC,
		S_BKT_RD,
		S_BKT_CHK,
		S_SCLR,
		S_BLD_RD,
		S_BLD_CHK,
		S_DIV,
		S_PRB_RD,
		S_PRB_CHK,
		S_SLOT_RD,
		S_SLOT_OUT,
		S_HDR_RD,
		S_HDR_OUT
	} state_t;

	typedef struct packed {
		logic           go;
		logic [DVD_W-1:0] dividend;
		logic [LEN_W-1:0] divisor;
	} div_req_t;

endpackage

/* hw/rtl/htb_mod.sv */
// iterative restoring remainder unit, one dividend bit per cycle
module htb_mod (
	input  logic                           clk,
	input  logic                           arst_n,
	input  htb_pkg::div_req_t              req,
	output logic                           done,
	output logic [htb_pkg::LEN_W-1:0]      rem
);

	logic [htb_pkg::DVD_W-1:0]  dvd_q;
	logic [htb_pkg::LEN_W-1:0]  dsr_q;
	logic [htb_pkg::LEN_W-1:0]  rem_q;
	logic [htb_pkg::DIV_CW-1:0] cnt_q;
	logic                       run_q;
	logic                       done_q;
	logic [htb_pkg::LEN_W-1:0]  trial;

	assign trial = {rem_q[htb_pkg::LEN_W-2:0], dvd_q[htb_pkg::DVD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				dvd_q <= req.dividend;
				dsr_q <= req.divisor;
				rem_q <= '0;
				cnt_q <= htb_pkg::DIV_CW'(htb_pkg::DVD_W - 1);
			end else if (run_q) begin
				dvd_q <= {dvd_q[htb_pkg::DVD_W-2:0], 1'b0};
				rem_q <= (trial >= dsr_q) ? trial - dsr_q : trial;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

/* hw/rtl/hash_table_builder_linear_probe_core.sv */
// hash table builder top level: entry store, bucket tally, table build and output sequencer
// add: result after states ADD1, ADD2 and ADD3; wrong phase or done: result straight from
// idle; next: header after HDR_RD and HDR_OUT, slot after SLOT_RD and SLOT_OUT once the
// table exists; building: tally clear plus entry count on the first next, a read per bucket
// visited, per non-empty bucket a clear of its 2*n slots, a read per entry scanned, a
// remainder from the bit-serial unit and a read per probe; busy stays high throughout
// reset: async active low, empty store, write position 4096, adding phase; results cannot stall
`include "hash_table_builder_linear_probe_core_assert.svh"
module hash_table_builder_linear_probe_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [31:0] key_len,
	input  logic [31:0] data_len,
	input  logic [63:0] hash_value,
	output logic        strobe,
	output logic [1:0]  status,
	output logic [1:0]  record_kind,
	output logic [63:0] word_a,
	output logic [63:0] word_b,
	output logic        last
);

	localparam int EW = htb_pkg::ENT_AW;
	localparam int CW = htb_pkg::CNT_W;
	localparam int SW = htb_pkg::SLOT_AW;
	localparam int LW = htb_pkg::LEN_W;
	localparam int BW = htb_pkg::BKT_W;

	htb_pkg::state_t state_q, state_d;
	htb_pkg::phase_t phase_q;

	logic [CW-1:0] total_q;
	logic [CW-1:0] e_q;
	logic [63:0]   wp_q;
	logic [63:0]   at_q;
	logic          ok_q;
	logic [31:0]   key_len_q;
	logic [31:0]   data_len_q;
	logic [BW-1:0] bucket_q;
	logic [LW-1:0] slot_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] cnt_q;
	logic [LW-1:0] w_q;

	logic          strobe_q;
	logic [1:0]    status_q;
	logic [1:0]    kind_q;
	logic [63:0]   word_a_q;
	logic [63:0]   word_b_q;
	logic          last_q;

	logic [63:0] ent_hash_mem [htb_pkg::MAX_ENTRIES];
	logic [63:0] ent_pos_mem  [htb_pkg::MAX_ENTRIES];
	logic [63:0] ent_hash_rd;
	logic [63:0] ent_pos_rd;
	logic        ent_we;

	logic [CW-1:0] tally_mem [htb_pkg::NUM_BUCKETS];
	logic [CW-1:0] tally_rd;
	logic [BW-1:0] tally_addr;
	logic          tally_we;
	logic [CW-1:0] tally_wd;

	logic [63:0] hdr_mem [htb_pkg::NUM_BUCKETS];
	logic [63:0] hdr_rd;
	logic        hdr_we;

	logic [63:0] slot_hash_mem [2 * htb_pkg::MAX_ENTRIES];
	logic [63:0] slot_pos_mem  [2 * htb_pkg::MAX_ENTRIES];
	logic [63:0] slot_hash_rd;
	logic [63:0] slot_pos_rd;
	logic [SW-1:0] slot_addr;
	logic        slot_we;
	logic [63:0] slot_wd_hash;
	logic [63:0] slot_wd_pos;

	logic [63:0] add_op;
	logic [64:0] add_sum;
	logic        add_fits;
	logic [63:0] wp_adv;
	logic        ok_adv;

	htb_pkg::div_req_t div_req;
	logic              div_done;
	logic [LW-1:0]     div_rem;

	logic          acc;
	logic [CW-1:0] e_inc;
	logic          e_last;
	logic [LW-1:0] w_inc;

	assign acc    = start && !busy;
	assign e_inc  = e_q + 1'b1;
	assign e_last = (e_inc == total_q);
	assign w_inc  = (w_q + 1'b1 == len_q) ? '0 : w_q + 1'b1;

	always_comb begin
		case (state_q)
			htb_pkg::S_ADD2: add_op = {32'd0, key_len_q};
			htb_pkg::S_ADD3: add_op = {32'd0, data_len_q};
			default:         add_op = 64'(htb_pkg::ENTRY_BYTES);
		endcase
	end

	assign add_sum  = {1'b0, wp_q} + {1'b0, add_op};
	assign add_fits = !add_sum[64];
	assign ok_adv   = ok_q && add_fits;
	assign wp_adv   = ok_adv ? add_sum[63:0] : wp_q;

	htb_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.rem    (div_rem)
	);

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_hash_mem[total_q[EW-1:0]] <= hash_value;
			ent_pos_mem[total_q[EW-1:0]]  <= wp_q;
		end
		ent_hash_rd <= ent_hash_mem[e_q[EW-1:0]];
		ent_pos_rd  <= ent_pos_mem[e_q[EW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (tally_we) begin
			tally_mem[tally_addr] <= tally_wd;
		end
		tally_rd <= tally_mem[tally_addr];
	end

	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_mem[bucket_q] <= wp_q;
		end
		hdr_rd <= hdr_mem[bucket_q];
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_hash_mem[slot_addr] <= slot_wd_hash;
			slot_pos_mem[slot_addr]  <= slot_wd_pos;
		end
		slot_hash_rd <= slot_hash_mem[slot_addr];
		slot_pos_rd  <= slot_pos_mem[slot_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ent_we       = 1'b0;
		tally_we     = 1'b0;
		tally_addr   = bucket_q;
		tally_wd     = '0;
		hdr_we       = 1'b0;
		slot_we      = 1'b0;
		slot_addr    = slot_q[SW-1:0];
		slot_wd_hash = '0;
		slot_wd_pos  = '0;
		div_req      = '{go: 1'b0, dividend: ent_hash_rd[63:BW], divisor: len_q};
		unique case (state_q)
			htb_pkg::S_IDLE: begin
				if (acc && func == htb_pkg::FUNC_ADD) begin
					if (phase_q == htb_pkg::PH_ADD &&
							total_q < CW'(htb_pkg::MAX_ENTRIES)) begin
						ent_we  = 1'b1;
						state_d = htb_pkg::S_ADD1;
					end
				end else if (acc) begin
					unique case (phase_q)
						htb_pkg::PH_ADD:  state_d = htb_pkg::S_CLR;
						htb_pkg::PH_SLOT: state_d = htb_pkg::S_BKT_RD;
						htb_pkg::PH_HDR:  state_d = htb_pkg::S_HDR_RD;
						default:          state_d = htb_pkg::S_IDLE;
					endcase
				end
			end
			htb_pkg::S_ADD1: state_d = htb_pkg::S_ADD2;
			htb_pkg::S_ADD2: state_d = htb_pkg::S_ADD3;
			htb_pkg::S_ADD3: state_d = htb_pkg::S_IDLE;
			htb_pkg::S_CLR: begin
				tally_addr = cnt_q[BW-1:0];
				tally_we   = 1'b1;
				if (cnt_q == LW'(htb_pkg::NUM_BUCKETS - 1)) begin
					state_d = (total_q == '0) ? htb_pkg::S_BKT_RD : htb_pkg::S_CNT_RD;
				end
			end
			htb_pkg::S_CNT_RD: state_d = htb_pkg::S_CNT_W1;
			htb_pkg::S_CNT_W1: begin
				tally_addr = ent_hash_rd[BW-1:0];
				state_d    = htb_pkg::S_CNT_INC;
			end
			htb_pkg::S_CNT_INC: begin
				tally_addr = ent_hash_rd[BW-1:0];
				tally_we   = 1'b1;
				tally_wd   = tally_rd + 1'b1;
				state_d    = e_last ? htb_pkg::S_BKT_RD : htb_pkg::S_CNT_RD;
			end
			htb_pkg::S_BKT_RD: state_d = htb_pkg::S_BKT_CHK;
			htb_pkg::S_BKT_CHK: begin
				hdr_we = (slot_q == '0);
				if (tally_rd == '0) begin
					state_d = (bucket_q == BW'(htb_pkg::NUM_BUCKETS - 1)) ?
						htb_pkg::S_HDR_RD : htb_pkg::S_BKT_RD;
				end else begin
					state_d = (slot_q == '0) ? htb_pkg::S_SCLR : htb_pkg::S_SLOT_RD;
				end
			end
			htb_pkg::S_SCLR: begin
				slot_addr = cnt_q[SW-1:0];
				slot_we   = 1'b1;
				if (cnt_q + 1'b1 == len_q) begin
					state_d = htb_pkg::S_BLD_RD;
				end
			end
			htb_pkg::S_BLD_RD: state_d = htb_pkg::S_BLD_CHK;
			htb_pkg::S_BLD_CHK: begin
				if (ent_hash_rd[BW-1:0] == bucket_q) begin
					div_req.go = 1'b1;
					state_d    = htb_pkg::S_DIV;
				end else begin
					state_d = e_last ? htb_pkg::S_SLOT_RD : htb_pkg::S_BLD_RD;
				end
			end
			htb_pkg::S_DIV: begin
				if (div_done) begin
					state_d = htb_pkg::S_PRB_RD;
				end
			end
			htb_pkg::S_PRB_RD: begin
				slot_addr = w_q[SW-1:0];
				state_d   = htb_pkg::S_PRB_CHK;
			end
			htb_pkg::S_PRB_CHK: begin
				slot_addr = w_q[SW-1:0];
				if (slot_pos_rd != '0) begin
					state_d = htb_pkg::S_PRB_RD;
				end else begin
					slot_we      = 1'b1;
					slot_wd_hash = ent_hash_rd;
					slot_wd_pos  = ent_pos_rd;
					state_d      = e_last ? htb_pkg::S_SLOT_RD : htb_pkg::S_BLD_RD;
				end
			end
			htb_pkg::S_SLOT_RD:  state_d = htb_pkg::S_SLOT_OUT;
			htb_pkg::S_SLOT_OUT: state_d = htb_pkg::S_IDLE;
			htb_pkg::S_HDR_RD:   state_d = htb_pkg::S_HDR_OUT;
			htb_pkg::S_HDR_OUT:  state_d = htb_pkg::S_IDLE;
			default:             state_d = htb_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= htb_pkg::PH_ADD;
			total_q    <= '0;
			e_q        <= '0;
			wp_q       <= htb_pkg::WP_RESET;
			at_q       <= '0;
			ok_q       <= 1'b0;
			key_len_q  <= '0;
			data_len_q <= '0;
			bucket_q   <= '0;
			slot_q     <= '0;
			len_q      <= '0;
			cnt_q      <= '0;
			w_q        <= '0;
			strobe_q   <= 1'b0;
			status_q   <= htb_pkg::ST_OK;
			kind_q     <= htb_pkg::KIND_ACK;
			word_a_q   <= '0;
			word_b_q   <= '0;
			last_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				htb_pkg::S_IDLE: begin
					cnt_q <= '0;
					if (acc && func == htb_pkg::FUNC_ADD) begin
						if (phase_q != htb_pkg::PH_ADD) begin
							strobe_q <= 1'b1;
							status_q <= htb_pkg::ST_PHASE;
							kind_q   <= htb_pkg::KIND_ACK;
							word_a_q <= '0;
							word_b_q <= '0;
							last_q   <= 1'b0;
						end else if (total_q >= CW'(htb_pkg::MAX_ENTRIES)) begin
							strobe_q <= 1'b1;
							status_q <= htb_pkg::ST_FULL;
							kind_q   <= htb_pkg::KIND_ACK;
							word_a_q <= '0;
							word_b_q <= '0;
							last_q   <= 1'b0;
						end else begin
							total_q    <= total_q + 1'b1;
							at_q       <= wp_q;
							ok_q       <= 1'b1;
							key_len_q  <= key_len;
							data_len_q <= data_len;
						end
					end else if (acc) begin
						if (phase_q == htb_pkg::PH_ADD) begin
							phase_q  <= htb_pkg::PH_SLOT;
							bucket_q <= '0;
							slot_q   <= '0;
							e_q      <= '0;
						end else if (phase_q == htb_pkg::PH_DONE) begin
							strobe_q <= 1'b1;
							status_q <= htb_pkg::ST_PHASE;
							kind_q   <= htb_pkg::KIND_ACK;
							word_a_q <= '0;
							word_b_q <= '0;
							last_q   <= 1'b0;
						end
					end
				end
				htb_pkg::S_ADD1, htb_pkg::S_ADD2: begin
					wp_q <= wp_adv;
					ok_q <= ok_adv;
				end
				htb_pkg::S_ADD3: begin
					wp_q     <= wp_adv;
					strobe_q <= 1'b1;
					status_q <= ok_adv ? htb_pkg::ST_OK : htb_pkg::ST_OVF;
					kind_q   <= htb_pkg::KIND_ACK;
					word_a_q <= at_q;
					word_b_q <= wp_adv;
					last_q   <= 1'b0;
				end
				htb_pkg::S_CLR: begin
					cnt_q <= cnt_q + 1'b1;
				end
				htb_pkg::S_CNT_INC: begin
					e_q <= e_inc;
				end
				htb_pkg::S_BKT_CHK: begin
					cnt_q <= '0;
					e_q   <= '0;
					len_q <= {tally_rd, 1'b0};
					if (tally_rd == '0) begin
						bucket_q <= bucket_q + 1'b1;
						if (bucket_q == BW'(htb_pkg::NUM_BUCKETS - 1)) begin
							phase_q <= htb_pkg::PH_HDR;
						end
					end
				end
				htb_pkg::S_SCLR: begin
					cnt_q <= cnt_q + 1'b1;
				end
				htb_pkg::S_BLD_CHK: begin
					if (ent_hash_rd[BW-1:0] != bucket_q) begin
						e_q <= e_inc;
					end
				end
				htb_pkg::S_DIV: begin
					w_q <= div_rem;
				end
				htb_pkg::S_PRB_CHK: begin
					if (slot_pos_rd != '0) begin
						w_q <= w_inc;
					end else begin
						e_q <= e_inc;
					end
				end
				htb_pkg::S_SLOT_OUT: begin
					if (add_fits) begin
						wp_q <= add_sum[63:0];
					end
					strobe_q <= 1'b1;
					status_q <= add_fits ? htb_pkg::ST_OK : htb_pkg::ST_OVF;
					kind_q   <= htb_pkg::KIND_SLOT;
					word_a_q <= slot_hash_rd;
					word_b_q <= slot_pos_rd;
					last_q   <= 1'b0;
					if (slot_q + 1'b1 == len_q) begin
						slot_q   <= '0;
						bucket_q <= bucket_q + 1'b1;
						if (bucket_q == BW'(htb_pkg::NUM_BUCKETS - 1)) begin
							phase_q <= htb_pkg::PH_HDR;
						end
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				htb_pkg::S_HDR_OUT: begin
					strobe_q <= 1'b1;
					status_q <= htb_pkg::ST_OK;
					kind_q   <= htb_pkg::KIND_HDR;
					word_a_q <= hdr_rd;
					word_b_q <= {{(64 - LW){1'b0}}, tally_rd, 1'b0};
					last_q   <= (bucket_q == BW'(htb_pkg::NUM_BUCKETS - 1));
					bucket_q <= bucket_q + 1'b1;
					if (bucket_q == BW'(htb_pkg::NUM_BUCKETS - 1)) begin
						phase_q <= htb_pkg::PH_DONE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign busy        = (state_q != htb_pkg::S_IDLE);
	assign strobe      = strobe_q;
	assign status      = status_q;
	assign record_kind = kind_q;
	assign word_a      = word_a_q;
	assign word_b      = word_b_q;
	assign last        = last_q;

	`HTB_ASSERT_NOW(a_last_on_header, strobe_q && last_q, kind_q == htb_pkg::KIND_HDR)
	`HTB_ASSERT_NOW(a_header_ok, strobe_q && kind_q == htb_pkg::KIND_HDR, status_q == htb_pkg::ST_OK)
	`HTB_ASSERT_NOW(a_div_len, state_q == htb_pkg::S_DIV, len_q != '0)
	`HTB_ASSERT_NEXT(a_add_counts, acc && func == htb_pkg::FUNC_ADD && phase_q == htb_pkg::PH_ADD && total_q < CW'(htb_pkg::MAX_ENTRIES), total_q == $past(total_q) + 1'b1)

endmodule
